// ===== sv/ppu_pkg.sv =====
// Shared types, codes and saturation helpers for the particle pool update block.
// No dependencies.
package ppu_pkg;

	localparam int POOL_SIZE_DEF = 64;

	// operation codes
	localparam logic [1:0] OP_SPAWN  = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_KILL   = 2'd2;

	// group types
	localparam logic [1:0] GT_SPARKS = 2'd0;
	localparam logic [1:0] GT_SMOKE  = 2'd1;

	// register decode on paddr[2]
	localparam logic REG_GROUP   = 1'b0;
	localparam logic REG_GRAVITY = 1'b1;

	localparam logic [30:0] GRAVITY_RESET = 31'd642908;

	typedef struct packed {
		logic [5:0]         slot;
		logic               alive;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0]        size;
		logic [30:0]        age;
		logic               accepted;
		logic               last;
	} res_t;

	// clamp a widened signed sum to the signed 32-bit range
	function automatic logic signed [31:0] sat_s32(input logic signed [36:0] x);
		logic signed [31:0] r;
		r = x[31:0];
		if (x > 37'sh00_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -37'sh00_8000_0000)
			r = 32'sh8000_0000;
		return r;
	endfunction

	// clamp a non-negative sum to 0..2^31-1
	function automatic logic [30:0] sat_u31(input logic [32:0] x);
		logic [30:0] r;
		r = x[30:0];
		if (x[32:31] != 2'b00)
			r = 31'h7FFF_FFFF;
		return r;
	endfunction

endpackage

// ===== sv/ppu_cmd_if.sv =====
// Request channel of the particle pool update block.
// No dependencies.
interface ppu_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [15:0]        dt;
	logic signed [31:0] spawn_pos_x;
	logic signed [31:0] spawn_pos_y;
	logic signed [31:0] spawn_pos_z;
	logic signed [31:0] spawn_vel_x;
	logic signed [31:0] spawn_vel_y;
	logic signed [31:0] spawn_vel_z;
	logic [30:0]        spawn_life;
	logic [30:0]        spawn_size;

	modport source(output valid, op, dt, spawn_pos_x, spawn_pos_y, spawn_pos_z,
		spawn_vel_x, spawn_vel_y, spawn_vel_z, spawn_life, spawn_size, input ready);
	modport sink(input valid, op, dt, spawn_pos_x, spawn_pos_y, spawn_pos_z,
		spawn_vel_x, spawn_vel_y, spawn_vel_z, spawn_life, spawn_size, output ready);
endinterface

// ===== sv/ppu_res_if.sv =====
// Result channel of the particle pool update block.
// No dependencies.
interface ppu_res_if;
	logic               valid;
	logic               ready;
	logic [5:0]         slot;
	logic               alive;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic [30:0]        out_size;
	logic [30:0]        out_age;
	logic               accepted;
	logic               last;

	modport source(output valid, slot, alive, out_pos_x, out_pos_y, out_pos_z,
		out_size, out_age, accepted, last, input ready);
	modport sink(input valid, slot, alive, out_pos_x, out_pos_y, out_pos_z,
		out_size, out_age, accepted, last, output ready);
endinterface

// ===== sv/ppu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/particle_pool_update_top.sv =====
// Top level of the particle pool update block: sequencer, shared multiplier,
// slot memories and APB register port. Depends on ppu_pkg, ppu_cmd_if,
// ppu_res_if and ppu_ram.
//
//  channel | dir | handshake       | carries
//  cmd     | in  | valid/ready     | op, dt, spawn fields
//  res     | out | valid/ready     | slot, alive, position, size, age, accepted, last
//  apb     | in  | psel/penable    | group_type (0x0), gravity (0x4)
//
// Spawn scans the flags one slot a cycle, starting at slot 0.
// Update forms gravity times dt, then visits each slot: a free slot is reported at
// once; an active one moves on x, y and z, then sparks lose gravity on vy and smoke
// grows and damps vx, vz, unless it dies; one 33x19 multiplier serves all products.
// Kill-all and op 3 answer with a single result. No clearing pass after reset.
// The block takes no request until the last result of the current one is taken.
module particle_pool_update_top #(
	parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ppu_cmd_if.sink     cmd,
	ppu_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ppu_pkg::*;

	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SCAN = 9'b000000010,
		S_GDT  = 9'b000000100,
		S_RD   = 9'b000001000,
		S_LD   = 9'b000010000,
		S_MUL  = 9'b000100000,
		S_ADD  = 9'b001000000,
		S_WB   = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [1:0]  group_q;
	logic [30:0] gravity_q;

	// APB registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q   <= GT_SPARKS;
			gravity_q <= GRAVITY_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_GROUP:   group_q   <= pwdata[1:0];
				REG_GRAVITY: gravity_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end
	assign prdata = (paddr[2] == REG_GRAVITY) ? {1'b0, gravity_q} : {30'd0, group_q};

	// captured request
	logic [15:0]        dt_q;
	logic signed [31:0] sp_px_q, sp_py_q, sp_pz_q, sp_vx_q, sp_vy_q, sp_vz_q;
	logic [30:0]        sp_life_q, sp_size_q;

	// working slot state
	logic [IDX_W-1:0]    slot_q;
	logic [POOL_SIZE-1:0] alive_q;
	logic [2:0]          sel_q;
	logic signed [31:0]  px_q, py_q, pz_q, vx_q, vy_q, vz_q;
	logic [30:0]         size_q, age_q, life_q;
	logic [30:0]         gdt_q;
	logic signed [51:0]  prod_q;
	res_t                res_q;
	logic                res_valid_q;

	// memories
	logic               ram_we;
	logic [95:0]        pos_wdata, vel_wdata, pos_rdata, vel_rdata;
	logic [92:0]        misc_wdata, misc_rdata;

	always_comb begin
		if (state_q == S_SCAN) begin
			pos_wdata  = {sp_pz_q, sp_py_q, sp_px_q};
			vel_wdata  = {sp_vz_q, sp_vy_q, sp_vx_q};
			misc_wdata = {sp_life_q, 31'd0, sp_size_q};
		end else begin
			pos_wdata  = {pz_q, py_q, px_q};
			vel_wdata  = {vz_q, vy_q, vx_q};
			misc_wdata = {life_q, age_q, size_q};
		end
	end
	assign ram_we = (state_q == S_WB) || (state_q == S_SCAN && !alive_q[slot_q]);

	ppu_ram #(.WIDTH(96), .DEPTH(POOL_SIZE)) u_pos_ram (
		.clk(clk), .we(ram_we), .waddr(slot_q), .wdata(pos_wdata),
		.raddr(slot_q), .rdata(pos_rdata));
	ppu_ram #(.WIDTH(96), .DEPTH(POOL_SIZE)) u_vel_ram (
		.clk(clk), .we(ram_we), .waddr(slot_q), .wdata(vel_wdata),
		.raddr(slot_q), .rdata(vel_rdata));
	ppu_ram #(.WIDTH(93), .DEPTH(POOL_SIZE)) u_misc_ram (
		.clk(clk), .we(ram_we), .waddr(slot_q), .wdata(misc_wdata),
		.raddr(slot_q), .rdata(misc_rdata));

	// shared multiplier operands
	logic [17:0]        k_dmp;
	logic signed [32:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [35:0] prod_fl;
	logic [32:0]        age_nx;

	assign k_dmp = 18'(({3'd0, dt_q} * 19'd5) >> 1);
	always_comb begin
		if (state_q == S_GDT) begin
			mul_a = {2'b00, gravity_q};
			mul_b = {3'b000, dt_q};
		end else begin
			unique case (sel_q)
				3'd0, 3'd3: mul_a = {vx_q[31], vx_q};
				3'd1:       mul_a = {vy_q[31], vy_q};
				default:    mul_a = {vz_q[31], vz_q};
			endcase
			mul_b = (sel_q >= 3'd3) ? {1'b0, k_dmp} : {3'b000, dt_q};
		end
	end
	assign prod_fl = prod_q[51:16];
	assign age_nx  = {2'b00, age_q} + {17'd0, dt_q};

	function automatic res_t dead_res(input logic [5:0] s, input logic acc,
			input logic lst);
		res_t r;
		r = '0;
		r.slot     = s;
		r.accepted = acc;
		r.last     = lst;
		return r;
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alive_q     <= '0;
			res_valid_q <= 1'b0;
			slot_q      <= '0;
			sel_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						dt_q      <= cmd.dt;
						sp_px_q   <= cmd.spawn_pos_x;
						sp_py_q   <= cmd.spawn_pos_y;
						sp_pz_q   <= cmd.spawn_pos_z;
						sp_vx_q   <= cmd.spawn_vel_x;
						sp_vy_q   <= cmd.spawn_vel_y;
						sp_vz_q   <= cmd.spawn_vel_z;
						sp_life_q <= cmd.spawn_life;
						sp_size_q <= cmd.spawn_size;
						slot_q    <= '0;
						if (cmd.op == OP_SPAWN)
							state_q <= S_SCAN;
						else if (cmd.op == OP_UPDATE)
							state_q <= S_GDT;
						else begin
							if (cmd.op == OP_KILL)
								alive_q <= '0;
							res_q       <= dead_res(6'd0, 1'b1, 1'b1);
							res_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					if (!alive_q[slot_q]) begin
						alive_q[slot_q] <= 1'b1;
						res_q <= '{slot: 6'(slot_q), alive: 1'b1, pos_x: sp_px_q,
							pos_y: sp_py_q, pos_z: sp_pz_q, size: sp_size_q,
							age: 31'd0, accepted: 1'b1, last: 1'b1};
						res_valid_q    <= 1'b1;
						state_q        <= S_OUT;
					end else if (slot_q == LAST_IDX) begin
						res_q       <= dead_res(6'd0, 1'b0, 1'b1);
						res_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else
						slot_q <= slot_q + 1'b1;
				end
				S_GDT: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_RD;
				end
				S_RD: begin
					// the gravity product is still in the register on the first slot
					if (slot_q == '0)
						gdt_q <= prod_q[46:16];
					if (alive_q[slot_q])
						state_q <= S_LD;
					else begin
						res_q       <= dead_res(6'(slot_q), 1'b1, slot_q == LAST_IDX);
						res_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_LD: begin
					{pz_q, py_q, px_q}       <= pos_rdata;
					{vz_q, vy_q, vx_q}       <= vel_rdata;
					{life_q, age_q, size_q}  <= misc_rdata;
					sel_q   <= 3'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_ADD;
				end
				S_ADD: begin
					unique case (sel_q)
						3'd0: begin
							px_q    <= sat_s32(37'(px_q) + 37'(prod_fl));
							sel_q   <= 3'd1;
							state_q <= S_MUL;
						end
						3'd1: begin
							py_q    <= sat_s32(37'(py_q) + 37'(prod_fl));
							sel_q   <= 3'd2;
							state_q <= S_MUL;
						end
						3'd2: begin
							pz_q  <= sat_s32(37'(pz_q) + 37'(prod_fl));
							age_q <= sat_u31(age_nx);
							if (group_q == GT_SMOKE) begin
								if (sat_u31(age_nx) > life_q) begin
									alive_q[slot_q] <= 1'b0;
									res_q       <= dead_res(6'(slot_q), 1'b1,
										slot_q == LAST_IDX);
									res_valid_q <= 1'b1;
									state_q     <= S_OUT;
								end else begin
									size_q  <= sat_u31({2'b00, size_q} + {18'd0, dt_q[15:1]});
									sel_q   <= 3'd3;
									state_q <= S_MUL;
								end
							end else if (group_q == GT_SPARKS) begin
								if (py_q[31]) begin
									alive_q[slot_q] <= 1'b0;
									res_q       <= dead_res(6'(slot_q), 1'b1,
										slot_q == LAST_IDX);
									res_valid_q <= 1'b1;
									state_q     <= S_OUT;
								end else begin
									vy_q    <= sat_s32(37'(vy_q) - {6'd0, gdt_q});
									state_q <= S_WB;
								end
							end else
								state_q <= S_WB;
						end
						3'd3: begin
							vx_q    <= sat_s32(37'(vx_q) - 37'(prod_fl));
							sel_q   <= 3'd4;
							state_q <= S_MUL;
						end
						default: begin
							vz_q    <= sat_s32(37'(vz_q) - 37'(prod_fl));
							state_q <= S_WB;
						end
					endcase
				end
				S_WB: begin
					res_q.slot     <= 6'(slot_q);
					res_q.alive    <= 1'b1;
					res_q.pos_x    <= px_q;
					res_q.pos_y    <= py_q;
					res_q.pos_z    <= pz_q;
					res_q.size     <= size_q;
					res_q.age      <= age_q;
					res_q.accepted <= 1'b1;
					res_q.last     <= (slot_q == LAST_IDX);
					res_valid_q    <= 1'b1;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) begin
						res_valid_q <= 1'b0;
						if (res_q.last)
							state_q <= S_IDLE;
						else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready     = (state_q == S_IDLE);
	assign res.valid     = res_valid_q;
	assign res.slot      = res_q.slot;
	assign res.alive     = res_q.alive;
	assign res.out_pos_x = res_q.pos_x;
	assign res.out_pos_y = res_q.pos_y;
	assign res.out_pos_z = res_q.pos_z;
	assign res.out_size  = res_q.size;
	assign res.out_age   = res_q.age;
	assign res.accepted  = res_q.accepted;
	assign res.last      = res_q.last;
endmodule

// ===== tb/ppu_tb_if.sv =====
// Testbench-side note: the block's channel interfaces come from the RTL (ppu_cmd_if,
// ppu_res_if). This file only holds the stimulus record type. Depends on ppu_pkg.
package ppu_tb_pkg;
	import ppu_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic [15:0]        dt;
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic [30:0]        life;
		logic [30:0]        size;
	} request_t;
endpackage

// ===== tb/particle_pool_update_top_test.sv =====
// Self-checking testbench of particle_pool_update_top: a directed table then random
// spawn/update/kill requests, results checked against an in-bench particle predictor.
// Depends on ppu_pkg, ppu_tb_pkg, ppu_cmd_if, ppu_res_if and the block.
module particle_pool_update_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ppu_pkg::*;
	import ppu_tb_pkg::*;

	localparam int NSLOT = 64;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [1:0] GT_PLAIN = 2'd2;
	localparam logic [1:0] GT_ODD = 2'd3;
	localparam logic [2:0] ADDR_GROUP = 3'd0;
	localparam logic [2:0] ADDR_GRAVITY = 3'd4;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ppu_cmd_if cmd();
	ppu_res_if res();

	particle_pool_update_top uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [1:0] mdl_group;
	logic [30:0] mdl_gravity;
	logic mdl_active [NSLOT];
	logic signed [31:0] mdl_pos [NSLOT][3];
	logic signed [31:0] mdl_vel [NSLOT][3];
	logic signed [31:0] mdl_size [NSLOT];
	logic signed [31:0] mdl_age [NSLOT];
	logic signed [31:0] mdl_life [NSLOT];

	res_t expected_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit sending_done = 1'b0;
	bit hold_off = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint floor16(longint x);
		return x >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp_s32(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] clamp_u31(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < 0) return 0;
		return x[31:0];
	endfunction

	function automatic res_t slot_report(int s, logic acc, logic lst);
		res_t r;
		r = '0;
		r.slot = s[5:0];
		r.alive = mdl_active[s];
		if (mdl_active[s]) begin
			r.pos_x = mdl_pos[s][0];
			r.pos_y = mdl_pos[s][1];
			r.pos_z = mdl_pos[s][2];
			r.size = mdl_size[s][30:0];
			r.age = mdl_age[s][30:0];
		end
		r.accepted = acc;
		r.last = lst;
		return r;
	endfunction

	// one Euler step of an active particle
	task automatic move_particle(int s, longint dt, longint gdt);
		longint k;
		for (int a = 0; a < 3; a++)
			mdl_pos[s][a] = clamp_s32(longint'(mdl_pos[s][a]) + floor16(mdl_vel[s][a] * dt));
		mdl_age[s] = clamp_u31(longint'(mdl_age[s]) + dt);
		if (mdl_group == GT_SMOKE) begin
			if (mdl_age[s] > mdl_life[s]) begin
				mdl_active[s] = 1'b0;
			end else begin
				k = (5 * dt) >>> 1;
				mdl_size[s] = clamp_u31(longint'(mdl_size[s]) + (dt >>> 1));
				mdl_vel[s][0] = clamp_s32(longint'(mdl_vel[s][0]) - floor16(k * mdl_vel[s][0]));
				mdl_vel[s][2] = clamp_s32(longint'(mdl_vel[s][2]) - floor16(k * mdl_vel[s][2]));
			end
		end else if (mdl_group == GT_SPARKS) begin
			if (mdl_pos[s][1] < 0) mdl_active[s] = 1'b0;
			else mdl_vel[s][1] = clamp_s32(longint'(mdl_vel[s][1]) - gdt);
		end
	endtask

	// work out the results of one accepted request and queue them
	task automatic predict_pool(request_t q);
		int s;
		longint dt, gdt;
		res_t r;
		dt = longint'(q.dt);
		case (q.op)
			OP_SPAWN: begin
				s = 0;
				while (s < NSLOT && mdl_active[s]) s++;
				if (s >= NSLOT) begin
					r = '0;
					r.last = 1'b1;
					expected_q.push_back(r);
				end else begin
					mdl_pos[s] = '{q.px, q.py, q.pz};
					mdl_vel[s] = '{q.vx, q.vy, q.vz};
					mdl_life[s] = {1'b0, q.life};
					mdl_size[s] = {1'b0, q.size};
					mdl_age[s] = 0;
					mdl_active[s] = 1'b1;
					expected_q.push_back(slot_report(s, 1'b1, 1'b1));
				end
			end
			OP_UPDATE: begin
				gdt = floor16(longint'(mdl_gravity) * dt);
				for (s = 0; s < NSLOT; s++) begin
					if (mdl_active[s]) move_particle(s, dt, gdt);
					expected_q.push_back(slot_report(s, 1'b1, s == NSLOT - 1));
				end
			end
			default: begin
				if (q.op == OP_KILL)
					for (s = 0; s < NSLOT; s++) mdl_active[s] = 1'b0;
				r = '0;
				r.accepted = 1'b1;
				r.last = 1'b1;
				expected_q.push_back(r);
			end
		endcase
	endtask

	// APB write: setup phase, access phase, then the bus returns to idle
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_GROUP) mdl_group = data[1:0];
		else mdl_gravity = data[30:0];
		@(posedge clk);
	endtask

	// drop the request line, wait for the expected results to drain, then let trailing work finish
	task automatic wait_quiet();
		cmd.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// with no gap the next request follows straight on from the accepted one
	task automatic send_request(request_t q);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= q.op;
		cmd.dt <= q.dt;
		cmd.spawn_pos_x <= q.px;
		cmd.spawn_pos_y <= q.py;
		cmd.spawn_pos_z <= q.pz;
		cmd.spawn_vel_x <= q.vx;
		cmd.spawn_vel_y <= q.vy;
		cmd.spawn_vel_z <= q.vz;
		cmd.spawn_life <= q.life;
		cmd.spawn_size <= q.size;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		predict_pool(q);
	endtask

	function automatic request_t make_request(logic [1:0] op, logic [15:0] dt,
			logic signed [31:0] p, logic signed [31:0] v, logic [30:0] life,
			logic [30:0] size);
		request_t q;
		q.op = op;
		q.dt = dt;
		q.px = p; q.py = p; q.pz = p;
		q.vx = v; q.vy = v; q.vz = v;
		q.life = life;
		q.size = size;
		return q;
	endfunction

	function automatic request_t random_request();
		request_t q;
		int pick;
		pick = $urandom_range(0, 99);
		q.op = pick < 55 ? OP_SPAWN : pick < 90 ? OP_UPDATE : pick < 96 ? OP_KILL : OP_NONE;
		q.dt = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000));
		q.px = $urandom; q.pz = $urandom;
		q.vx = $urandom; q.vz = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			q.py = $urandom_range(0, 32'h00A0_0000);
			q.vy = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			q.vx = $signed(q.vx) >>> 8;
			q.vz = $signed(q.vz) >>> 8;
		end else begin
			q.py = $urandom;
			q.vy = $urandom;
		end
		q.life = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
		q.size = 31'($urandom);
		return q;
	endfunction

	// directed table; results checked by the predictor
	request_t directed [] = '{
		make_request(OP_UPDATE, 16'hFFFF, 0, 0, 0, 0),
		make_request(OP_SPAWN, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
		make_request(OP_SPAWN, 16'hFFFF, 32'sh8000_0000, 32'sh8000_0000, 0, 0),
		make_request(OP_SPAWN, 0, 32'sh0001_0000, -32'sh0002_0000, 31'h0000_8000, 31'd1),
		make_request(OP_UPDATE, 16'hFFFF, 0, 0, 0, 0),
		make_request(OP_UPDATE, 16'd0, 0, 0, 0, 0),
		make_request(OP_NONE, 16'hFFFF, 0, 0, 0, 0),
		make_request(OP_KILL, 0, 0, 0, 0, 0),
		make_request(OP_UPDATE, 16'h1000, 0, 0, 0, 0)
	};

	// stimulus sequence: directed table, pool fill, then random phases
	initial begin
		request_t q;
		logic [1:0] groups [] = '{GT_SPARKS, GT_SMOKE, GT_PLAIN, GT_ODD, GT_SPARKS};
		logic [31:0] gravs [] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'd642908, 32'h0001_0000,
			32'h0003_0000};
		cmd.valid = 1'b0; cmd.op = '0; cmd.dt = '0;
		cmd.spawn_pos_x = '0; cmd.spawn_pos_y = '0; cmd.spawn_pos_z = '0;
		cmd.spawn_vel_x = '0; cmd.spawn_vel_y = '0; cmd.spawn_vel_z = '0;
		cmd.spawn_life = '0; cmd.spawn_size = '0;
		mdl_group = GT_SPARKS;
		mdl_gravity = GRAVITY_RESET;
		for (int s = 0; s < NSLOT; s++) begin
			mdl_active[s] = 1'b0;
			mdl_pos[s] = '{0, 0, 0};
			mdl_vel[s] = '{0, 0, 0};
			mdl_size[s] = 0; mdl_age[s] = 0; mdl_life[s] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset settings, then smoke
		foreach (directed[i]) send_request(directed[i]);
		wait_quiet();
		reg_write(ADDR_GROUP, {30'd0, GT_SMOKE});
		foreach (directed[i]) send_request(directed[i]);
		// fill the pool to reach the full-pool answer
		for (int i = 0; i < NSLOT + 2; i++)
			send_request(make_request(OP_SPAWN, 0, i << 16, 32'sh0000_1000, 31'h0010_0000, 31'd5));
		send_request(make_request(OP_UPDATE, 16'h8000, 0, 0, 0, 0));
		send_request(make_request(OP_KILL, 0, 0, 0, 0, 0));
		wait_quiet();

		// random part across several register settings
		for (int ph = 0; ph < 5; ph++) begin
			reg_write(ADDR_GROUP, {30'd0, groups[ph]});
			reg_write(ADDR_GRAVITY, gravs[ph]);
			if (ph == 2) hold_off = 1'b1;
			for (int i = 0; i < 27; i++) send_request(random_request());
			wait_quiet();
		end
		sending_done = 1'b1;
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off && !held) begin
				held = 1'b1;
				res.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!(res.valid && res.ready)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.slot, res.alive, res.out_pos_x, res.out_pos_y, res.out_pos_z,
				res.out_size, res.out_age, res.accepted, res.last};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("particle_pool_update_top_test: FAIL");
			$finish;
		end else if (sending_done) begin
			if (mismatches == 0 && expected_q.size() == 0)
				$display("particle_pool_update_top_test: PASS");
			else
				$display("particle_pool_update_top_test: FAIL");
			$finish;
		end
	end
endmodule
